### rtl/rhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_pkg
// Shared types and constants of the region hotness scoring core.
// ----------------------------------------------------------------------------
package rhs_pkg;

    // subscores and score scaling
    localparam int SUBSCORE_MAX  = 100;
    localparam int AGE_LOG_MAX   = 32;
    localparam int USEC_PER_SEC  = 1000000;
    localparam int MAX_SCORE_DEF = 99;

    // field widths
    localparam int CNT_W   = 16;
    localparam int AGE_W   = 32;
    localparam int WGT_W   = 16;
    localparam int SCORE_W = 7;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ_WEIGHT = 2'd0,
        CFG_AGE_WEIGHT  = 2'd1,
        CFG_MAX_COUNT   = 2'd2,
        CFG_INTERVAL_US = 2'd3
    } t_cfg_idx;

    // input word
    typedef struct packed {
        logic [CNT_W-1:0] access_count;
        logic [AGE_W-1:0] region_age;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [SCORE_W-1:0] hot_score;
        logic [SCORE_W-1:0] cold_score;
    } t_out_word;

endpackage

### rtl/region_hotness_score_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_hotness_score_core
// Scores one memory region per word from access count and age, giving
// hotness and coldness.
// ----------------------------------------------------------------------------
// The core takes one word every clock unless stalled and returns results in
// order. The path is an 11-stage register pipeline: a 32x32 age product, a
// compare bank giving the bit length of the age in seconds, two restoring
// dividers of three quotient bits per stage and the last bit in a stage of
// its own (one for the frequency subscore, one for the weighted average) and
// a final reciprocal multiply that scales the average to 0..MAX_SCORE. Every
// stage holds its word while the next one cannot take it, so results back up
// when the output is not taken and input is refused only once all stages are
// occupied. Configuration registers are read by the stages directly; the user
// must write them only while the core is empty; this is not enforced.
// MAX_SCORE ranges from 1 to 1000; both scores are reported modulo 128.
module region_hotness_score_core
    import rhs_pkg::*;
#(
    parameter int MAX_SCORE = MAX_SCORE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_data,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_data
);

    localparam int NSTG  = 11;
    localparam int NUM_W = 23;                       // count * 100
    localparam int WN_W  = 24;                       // weighted sum
    localparam int WS_W  = WGT_W + 1;                // weight sum
    localparam int Q_W   = 7;                        // quotients 0..100
    localparam int LEN_W = 6;                        // bit length 0..32
    localparam int OFF_W = 7;                        // offset length 0..64
    localparam int XW    = $clog2(SUBSCORE_MAX * MAX_SCORE + 1);
    localparam int RK    = XW + 7;                   // reciprocal shift
    localparam int RW    = RK + 1;
    localparam logic [RW-1:0] RECIP = RW'((2**RK + SUBSCORE_MAX - 1) / SUBSCORE_MAX);
    localparam int HOTW  = $clog2(MAX_SCORE + 1) + SCORE_W;
    localparam int PRW   = XW + RW;

    // configuration registers
    logic [WGT_W-1:0] r_freq_wgt;
    logic [WGT_W-1:0] r_age_wgt;
    logic [CNT_W-1:0] r_max_cnt;
    logic [AGE_W-1:0] r_intv_us;

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    // stage registers
    logic [NUM_W-1:0] r1_num;
    logic [CNT_W-1:0] r1_div;
    logic [63:0]      r1_prod;
    logic [NUM_W-1:0] r2_num;
    logic [CNT_W-1:0] r2_div;
    logic             r2_sat;
    logic [AGE_LOG_MAX-1:0] r2_ge;
    logic [NUM_W-1:0] r3_rem;
    logic [Q_W-1:0]   r3_q;
    logic [CNT_W-1:0] r3_div;
    logic             r3_sat;
    logic [LEN_W-1:0] r3_len;
    logic [NUM_W-1:0] r4_rem;
    logic [Q_W-1:0]   r4_q;
    logic [CNT_W-1:0] r4_div;
    logic             r4_sat;
    logic [LEN_W-1:0] r4_len;
    logic [Q_W-1:0]   r5_freq;
    logic [Q_W-1:0]   r5_agesub;
    logic [WN_W-1:0]  r6_wnum;
    logic [WS_W-1:0]  r6_wsum;
    logic [WN_W-1:0]  r7_rem;
    logic [Q_W-1:0]   r7_q;
    logic [WS_W-1:0]  r7_wsum;
    logic [WN_W-1:0]  r8_rem;
    logic [Q_W-1:0]   r8_q;
    logic [WS_W-1:0]  r8_wsum;
    logic [Q_W-1:0]   r9_avg;
    logic [XW-1:0]    r10_x;
    t_out_word        r11_out;

    // next values
    logic [NUM_W-1:0] n3_rem, n4_rem;
    logic [Q_W-1:0]   n3_q, n4_q;
    logic [LEN_W-1:0] n3_len;
    logic [AGE_LOG_MAX-1:0] n2_ge;
    logic [Q_W-1:0]   n5_q, n5_freq, n5_agesub;
    logic [OFF_W-1:0] n5_offs;
    logic [WN_W-1:0]  n7_rem, n8_rem;
    logic [Q_W-1:0]   n7_q, n8_q, n9_q;
    logic [PRW-1:0]   n11_prod;
    logic [HOTW-1:0]  n11_hot, n11_cold;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_wgt <= '0;
            r_age_wgt  <= '0;
            r_max_cnt  <= CNT_W'(20);
            r_intv_us  <= AGE_W'(100000);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FREQ_WEIGHT: r_freq_wgt <= i_cfg_data[WGT_W-1:0];
                CFG_AGE_WEIGHT:  r_age_wgt  <= i_cfg_data[WGT_W-1:0];
                CFG_MAX_COUNT:   r_max_cnt  <= i_cfg_data[CNT_W-1:0];
                CFG_INTERVAL_US: r_intv_us  <= i_cfg_data[AGE_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or the next stage loads
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NSTG-1];
    assign o_out_data  = r11_out;

    // valid bits travel with the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 2: saturation check and age threshold bank
    always_comb begin
        for (int k = 0; k < AGE_LOG_MAX; k++) begin
            n2_ge[k] = r1_prod >= (64'(USEC_PER_SEC) << k);
        end
    end

    // stage 3: bit length from thermometer, frequency quotient bits 6..4
    always_comb begin
        n3_len = '0;
        for (int k = 0; k < AGE_LOG_MAX; k++) begin
            if (r2_ge[k]) begin
                n3_len = LEN_W'(k + 1);
            end
        end
        n3_rem = r2_num;
        n3_q   = '0;
        for (int b = 6; b >= 4; b--) begin
            if (n3_rem >= (NUM_W'(r2_div) << b)) begin
                n3_rem  = n3_rem - (NUM_W'(r2_div) << b);
                n3_q[b] = 1'b1;
            end
        end
    end

    // stage 4: frequency quotient bits 3..1
    always_comb begin
        n4_rem = r3_rem;
        n4_q   = r3_q;
        for (int b = 3; b >= 1; b--) begin
            if (n4_rem >= (NUM_W'(r3_div) << b)) begin
                n4_rem  = n4_rem - (NUM_W'(r3_div) << b);
                n4_q[b] = 1'b1;
            end
        end
    end

    // stage 5: last quotient bit, saturation, age subscore
    always_comb begin
        n5_q = r4_q;
        if (r4_rem >= NUM_W'(r4_div)) begin
            n5_q[0] = 1'b1;
        end
        n5_freq = r4_sat ? Q_W'(SUBSCORE_MAX) : n5_q;
        if (n5_freq == '0) begin
            n5_offs = OFF_W'(AGE_LOG_MAX) - OFF_W'(r4_len);
        end else begin
            n5_offs = OFF_W'(AGE_LOG_MAX) + OFF_W'(r4_len);
        end
        // offs * 100 / 32 / 2 is offs * 100 / 64
        n5_agesub = Q_W'((14'(n5_offs) * 14'(SUBSCORE_MAX)) >> 6);
    end

    // stage 7: average quotient bits 6..4
    always_comb begin
        n7_rem = r6_wnum;
        n7_q   = '0;
        for (int b = 6; b >= 4; b--) begin
            if (n7_rem >= (WN_W'(r6_wsum) << b)) begin
                n7_rem  = n7_rem - (WN_W'(r6_wsum) << b);
                n7_q[b] = 1'b1;
            end
        end
    end

    // stage 8: average quotient bits 3..1
    always_comb begin
        n8_rem = r7_rem;
        n8_q   = r7_q;
        for (int b = 3; b >= 1; b--) begin
            if (n8_rem >= (WN_W'(r7_wsum) << b)) begin
                n8_rem  = n8_rem - (WN_W'(r7_wsum) << b);
                n8_q[b] = 1'b1;
            end
        end
    end

    // stage 9: last quotient bit, zero weight sum gives zero
    always_comb begin
        n9_q = r8_q;
        if (r8_rem >= WN_W'(r8_wsum)) begin
            n9_q[0] = 1'b1;
        end
        if (r8_wsum == '0) begin
            n9_q = '0;
        end
    end

    // stage 11: divide by 100 through reciprocal, coldness
    always_comb begin
        n11_prod = PRW'(r10_x) * PRW'(RECIP);
        n11_hot  = HOTW'(n11_prod >> RK);
        n11_cold = HOTW'(MAX_SCORE) - n11_hot;
    end

    // stage payload registers
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_num  <= NUM_W'(i_in_data.access_count) * NUM_W'(SUBSCORE_MAX);
            r1_div  <= (r_max_cnt == '0) ? CNT_W'(1) : r_max_cnt;
            r1_prod <= 64'(i_in_data.region_age) * 64'(r_intv_us);
        end
        if (w_en[1]) begin
            r2_num <= r1_num;
            r2_div <= r1_div;
            r2_sat <= r1_num >= (NUM_W'(r1_div) * NUM_W'(SUBSCORE_MAX + 1));
            r2_ge  <= n2_ge;
        end
        if (w_en[2]) begin
            r3_rem <= n3_rem;
            r3_q   <= n3_q;
            r3_div <= r2_div;
            r3_sat <= r2_sat;
            r3_len <= n3_len;
        end
        if (w_en[3]) begin
            r4_rem <= n4_rem;
            r4_q   <= n4_q;
            r4_div <= r3_div;
            r4_sat <= r3_sat;
            r4_len <= r3_len;
        end
        if (w_en[4]) begin
            r5_freq   <= n5_freq;
            r5_agesub <= n5_agesub;
        end
        if (w_en[5]) begin
            r6_wnum <= WN_W'(r_freq_wgt) * WN_W'(r5_freq)
                     + WN_W'(r_age_wgt) * WN_W'(r5_agesub);
            r6_wsum <= WS_W'(r_freq_wgt) + WS_W'(r_age_wgt);
        end
        if (w_en[6]) begin
            r7_rem  <= n7_rem;
            r7_q    <= n7_q;
            r7_wsum <= r6_wsum;
        end
        if (w_en[7]) begin
            r8_rem  <= n8_rem;
            r8_q    <= n8_q;
            r8_wsum <= r7_wsum;
        end
        if (w_en[8]) begin
            r9_avg <= n9_q;
        end
        if (w_en[9]) begin
            r10_x <= XW'(r9_avg) * XW'(MAX_SCORE);
        end
        if (w_en[10]) begin
            r11_out.hot_score  <= n11_hot[SCORE_W-1:0];
            r11_out.cold_score <= n11_cold[SCORE_W-1:0];
        end
    end

    // hot and cold always add up to the full score
    a_score_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (SCORE_W'(o_out_data.hot_score + o_out_data.cold_score)
                         == SCORE_W'(MAX_SCORE)))
        else $error("hot and cold scores do not sum to max score");

    // input is refused only when the whole pipeline is full and stalled
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> ((&r_vld) && !i_out_ready))
        else $error("input refused with room in the pipeline");

    // frequency subscore stays within 0..100
    a_freq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r5_freq <= Q_W'(SUBSCORE_MAX)))
        else $error("frequency subscore out of range");

    // weighted average stays within 0..100
    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[8] |-> (r9_avg <= Q_W'(SUBSCORE_MAX)))
        else $error("weighted average out of range");

    // a stalled output word keeps its valid bit
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("output word dropped while stalled");

endmodule
